[hw/rtl/sdtf_pkg.sv]
// Package with the shared constants and types of the signed decimal text formatter.
`timescale 1ns / 1ps

package sdtf_pkg;

  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned NumDigits   = 20;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned BcdWidth    = NumDigits * DigitWidth;
  localparam int unsigned LenWidth    = 5;
  localparam int unsigned CharWidth   = 8;
  localparam int unsigned BitCntWidth = $clog2(ValueWidth);
  localparam int unsigned FifoDepth   = 2;
  localparam int unsigned OutDataWidth = 16;

  localparam logic [CharWidth-1:0]  AsciiZero   = 8'd48;
  localparam logic [CharWidth-1:0]  AsciiMinus  = 8'd45;
  // A BCD digit of five or more is corrected by three before each doubling.
  localparam logic [DigitWidth-1:0] DabbleLimit  = 4'd5;
  localparam logic [DigitWidth-1:0] DabbleAdjust = 4'd3;

  typedef struct packed {
    logic                neg;
    logic [LenWidth-1:0] len;
    logic [BcdWidth-1:0] bcd;
  } sdtf_item_t;

  typedef enum logic [1:0] {
    FrontIdle,
    FrontConv,
    FrontDone
  } front_state_e;

  typedef enum logic {
    BackIdle,
    BackEmit
  } back_state_e;

endpackage

[hw/rtl/sdtf_front.sv]
// Front part: accepts a value, takes its magnitude and converts it to BCD bit by bit.
`timescale 1ns / 1ps

module sdtf_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [sdtf_pkg::ValueWidth-1:0]      in_value_i,
  output logic                                 item_valid_o,
  input  logic                                 item_ready_i,
  output sdtf_pkg::sdtf_item_t                 item_o
);
  import sdtf_pkg::*;

  front_state_e            state_q, state_d;
  logic [BitCntWidth-1:0]  cnt_q;
  logic [ValueWidth-1:0]   mag_q;
  logic [BcdWidth-1:0]     bcd_q;
  logic                    neg_q;
  logic [BcdWidth-1:0]     bcd_adj;
  logic [LenWidth-1:0]     num_dig;

  // Correct every digit before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*DigitWidth +: DigitWidth] >= DabbleLimit) begin
        bcd_adj[i*DigitWidth +: DigitWidth] = bcd_q[i*DigitWidth +: DigitWidth] + DabbleAdjust;
      end else begin
        bcd_adj[i*DigitWidth +: DigitWidth] = bcd_q[i*DigitWidth +: DigitWidth];
      end
    end
  end

  // Position of the highest nonzero digit; zero still yields one digit.
  always_comb begin
    num_dig = LenWidth'(1);
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*DigitWidth +: DigitWidth] != '0) begin
        num_dig = LenWidth'(i + 1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FrontIdle: begin
        if (in_valid_i) begin
          state_d = FrontConv;
        end
      end
      FrontConv: begin
        if (cnt_q == BitCntWidth'(ValueWidth - 1)) begin
          state_d = FrontDone;
        end
      end
      FrontDone: begin
        if (item_ready_i) begin
          state_d = FrontIdle;
        end
      end
      default: state_d = FrontIdle;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    item_valid_o = 1'b0;
    case (state_q)
      FrontIdle: in_ready_o   = 1'b1;
      FrontDone: item_valid_o = 1'b1;
      default: begin
        in_ready_o   = 1'b0;
        item_valid_o = 1'b0;
      end
    endcase
  end

  assign item_o.neg = neg_q;
  assign item_o.len = num_dig + LenWidth'(neg_q);
  assign item_o.bcd = bcd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrontIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FrontConv) begin
        cnt_q <= cnt_q + BitCntWidth'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FrontIdle && in_valid_i) begin
      neg_q <= in_value_i[ValueWidth-1];
      mag_q <= in_value_i[ValueWidth-1] ? (~in_value_i + ValueWidth'(1)) : in_value_i;
      bcd_q <= '0;
    end else if (state_q == FrontConv) begin
      {bcd_q, mag_q} <= {bcd_adj[BcdWidth-2:0], mag_q, 1'b0};
    end
  end

endmodule

[hw/rtl/sdtf_fifo.sv]
// Short queue of converted items between the front and back parts.
`timescale 1ns / 1ps

module sdtf_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  output logic                 wr_ready_o,
  input  sdtf_pkg::sdtf_item_t wr_item_i,
  output logic                 rd_valid_o,
  input  logic                 rd_ready_i,
  output sdtf_pkg::sdtf_item_t rd_item_o
);
  import sdtf_pkg::*;

  localparam int unsigned PtrWidth = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntWidth = $clog2(FifoDepth + 1);

  sdtf_item_t            mem_q [FifoDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]   count_q;
  logic                  push, pop;

  assign wr_ready_o = (count_q != CntWidth'(FifoDepth));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntWidth'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

[hw/rtl/sdtf_back.sv]
// Back part: turns a queued item into ASCII characters behind an output register.
`timescale 1ns / 1ps

module sdtf_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  item_valid_i,
  output logic                                  item_ready_o,
  input  sdtf_pkg::sdtf_item_t                  item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [sdtf_pkg::CharWidth-1:0]        out_char_o,
  output logic [sdtf_pkg::LenWidth-1:0]         out_len_o,
  output logic                                  out_last_o
);
  import sdtf_pkg::*;

  back_state_e           state_q, state_d;
  sdtf_item_t            cur_q;
  logic [LenWidth-1:0]   pos_q;
  logic                  out_valid_q;
  logic [CharWidth-1:0]  out_char_q;
  logic [LenWidth-1:0]   out_len_q;
  logic                  out_last_q;
  logic                  out_free;
  logic                  load_out;
  logic [LenWidth-1:0]   dig_idx;
  logic [DigitWidth-1:0] digit;
  logic [CharWidth-1:0]  next_char;
  logic                  next_last;

  assign out_free  = !out_valid_q || out_ready_i;
  assign dig_idx   = cur_q.len - LenWidth'(1) - pos_q;
  assign next_last = (pos_q == cur_q.len - LenWidth'(1));

  always_comb begin
    digit = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (dig_idx == LenWidth'(i)) begin
        digit = cur_q.bcd[i*DigitWidth +: DigitWidth];
      end
    end
  end

  always_comb begin
    if (cur_q.neg && pos_q == '0) begin
      next_char = AsciiMinus;
    end else begin
      next_char = AsciiZero + CharWidth'(digit);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BackIdle: begin
        if (item_valid_i) begin
          state_d = BackEmit;
        end
      end
      BackEmit: begin
        if (out_free && next_last) begin
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_comb begin
    item_ready_o = 1'b0;
    load_out     = 1'b0;
    case (state_q)
      BackIdle: item_ready_o = 1'b1;
      BackEmit: load_out     = out_free;
      default: begin
        item_ready_o = 1'b0;
        load_out     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (item_ready_o) begin
        pos_q <= '0;
      end else if (load_out) begin
        pos_q <= pos_q + LenWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      cur_q <= item_i;
    end
    if (load_out) begin
      out_char_q <= next_char;
      out_len_q  <= cur_q.len;
      out_last_q <= next_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_len_o   = out_len_q;
  assign out_last_o  = out_last_q;

endmodule

[hw/rtl/signed_decimal_text_formatter_unit.sv]
// Top level of the signed decimal text formatter: front converter, queue and character back end.
//
// Usage: the slave stream takes one signed 64-bit value per transfer on
// s_axis_tdata_i. The master stream returns its decimal ASCII text, one
// character per transfer, most significant character first, with a minus
// sign in front of negative values and no leading zeros (zero gives '0').
// Every character transfer carries the total text length, and tlast marks
// the final character of a value.
// Throughput: the front takes no new value until it has handed the last
// one to the queue; its bit-serial binary-to-BCD loop converts one magnitude
// bit per cycle over 64 bits. The back part emits one character per cycle
// while the receiver is ready, so even 20-character texts keep up with the front.
// A two-entry queue sits between the front and back parts, so conversion of
// the next value goes on while the characters of earlier ones are sent.
// When the receiver stalls, the output register holds its character and the
// queue fills; the front then keeps its converted item and takes no values.
// Reset empties the queue and returns both parts to idle; no transfer in
// flight survives it.
`timescale 1ns / 1ps

module signed_decimal_text_formatter_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input stream. tdata: value [63:0].
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [sdtf_pkg::ValueWidth-1:0]       s_axis_tdata_i,
  // Output stream. tdata: text_char [7:0], text_length [12:8], zero [15:13].
  // tlast: is_last.
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [sdtf_pkg::OutDataWidth-1:0]     m_axis_tdata_o,
  output logic                                  m_axis_tlast_o
);
  import sdtf_pkg::*;

  // Converted items flow from the front into the queue, then into the back.
  sdtf_item_t           front_item, queue_item;
  logic                 front_valid, front_ready;
  logic                 queue_valid, queue_ready;
  logic [CharWidth-1:0] text_char;
  logic [LenWidth-1:0]  text_length;

  sdtf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_value_i   (s_axis_tdata_i),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  sdtf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_item_i  (front_item),
    .rd_valid_o (queue_valid),
    .rd_ready_i (queue_ready),
    .rd_item_o  (queue_item)
  );

  sdtf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_ready_o (queue_ready),
    .item_i       (queue_item),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_char_o   (text_char),
    .out_len_o    (text_length),
    .out_last_o   (m_axis_tlast_o)
  );

  // Pack the character and the length; the upper bits stay zero.
  assign m_axis_tdata_o = {(OutDataWidth - CharWidth - LenWidth)'(0), text_length, text_char};

endmodule
